// ===== hw/rtl/sha256_pkg.sv =====
// shared constants and functions for the sha-256 block hasher
`default_nettype none
package sha256_pkg;

	localparam logic [255:0] InitHash = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] init_word(input logic [2:0] idx);
		init_word = InitHash[(3'd7 - idx) * 32 +: 32];
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		unique case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
		endcase
		round_k = k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// working variables a to h carried through every round
	typedef struct packed {
		logic [31:0] a, b, c, d, e, f, g, h;
	} sha_vars_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_round.sv =====
// one sha-256 round and schedule word, used once per cycle
`default_nettype none
module sha256_round import sha256_pkg::*; (
	input  wire sha_vars_t   vars,
	input  wire logic [31:0] k,
	input  wire logic        expand,
	input  wire logic [31:0] w0,
	input  wire logic [31:0] w1,
	input  wire logic [31:0] w9,
	input  wire logic [31:0] w14,
	output sha_vars_t        vars_next,
	output logic [31:0]      wt
);
	logic [31:0] sg0, sg1, s0, s1, ch, maj, t1, t2;

	// schedule word
	always_comb begin
		sg0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		sg1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		wt = expand ? (w0 + sg0 + w9 + sg1) : w0;
	end

	// round function
	always_comb begin
		s1 = rotr(vars.e, 6) ^ rotr(vars.e, 11) ^ rotr(vars.e, 25);
		ch = (vars.e & vars.f) ^ (~vars.e & vars.g);
		t1 = vars.h + s1 + ch + k + wt;
		s0 = rotr(vars.a, 2) ^ rotr(vars.a, 13) ^ rotr(vars.a, 22);
		maj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
		t2 = s0 + maj;
		vars_next.h = vars.g;
		vars_next.g = vars.f;
		vars_next.f = vars.e;
		vars_next.e = vars.d + t1;
		vars_next.d = vars.c;
		vars_next.c = vars.b;
		vars_next.b = vars.a;
		vars_next.a = t1 + t2;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_block_hasher_unit.sv =====
// sha-256 block hasher top level: word intake, round sequencer, digest output
// a word that does not end a block is taken without a stall
// a block's last word starts the round sequence and then the feed-forward add into the hash
// a message's last block then gives eight digest beats, one per cycle while out_stall is low
// the single round unit serves the rounds one after another, and no word is taken while a block is hashed
// reset restores the initial hash and clears all counters; no clearing pass
`default_nettype none
module sha256_block_hasher_unit import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] message_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       digest_index,
	output logic             digest_last
);
	localparam logic [1:0] StIn = 2'd0, StRound = 2'd1, StAdd = 2'd2, StOut = 2'd3;

	logic [1:0]  state_q;
	logic [15:0] bpm_q;
	logic [3:0]  word_q;
	logic [15:0] block_q;
	logic [5:0]  round_q;
	logic [2:0]  oidx_q;
	logic [31:0] win_q [16];
	logic [31:0] hash_q [8];
	sha_vars_t   vars_q, vars_next;
	logic [31:0] wt;
	logic [15:0] limit;
	logic        in_beat, out_beat;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != StIn);
	assign in_beat = in_valid && !in_stall;
	assign out_valid = (state_q == StOut);
	assign out_beat = out_valid && !out_stall;
	assign digest_word = hash_q[oidx_q];
	assign digest_index = oidx_q;
	assign digest_last = (oidx_q == 3'd7);
	assign limit = (bpm_q == 16'd0) ? 16'd1 : bpm_q;

	sha256_round u_round (
		.vars(vars_q), .k(round_k(round_q)), .expand(round_q[5:4] != 2'd0),
		.w0(win_q[round_q[3:0]]), .w1(win_q[round_q[3:0] + 4'd1]),
		.w9(win_q[round_q[3:0] + 4'd9]), .w14(win_q[round_q[3:0] + 4'd14]),
		.vars_next(vars_next), .wt(wt)
	);

	// schedule window
	always_ff @(posedge clk) begin
		if (in_beat) begin
			win_q[word_q] <= message_word;
		end else if (state_q == StRound) begin
			win_q[round_q[3:0]] <= wt;
		end
	end

	// working variables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= '0;
		end else if (in_beat && word_q == 4'd15) begin
			vars_q <= {hash_q[0], hash_q[1], hash_q[2], hash_q[3],
				hash_q[4], hash_q[5], hash_q[6], hash_q[7]};
		end else if (state_q == StRound) begin
			vars_q <= vars_next;
		end
	end

	// sequencer and hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIn;
			bpm_q <= 16'd1;
			word_q <= '0;
			block_q <= '0;
			round_q <= '0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= init_word(3'(i));
		end else begin
			if (cfg_valid) bpm_q <= cfg_data;
			unique case (state_q)
				StIn: begin
					if (in_beat) begin
						word_q <= word_q + 4'd1;
						if (word_q == 4'd15) begin
							state_q <= StRound;
							round_q <= '0;
						end
					end
				end
				StRound: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					hash_q[0] <= hash_q[0] + vars_q.a;
					hash_q[1] <= hash_q[1] + vars_q.b;
					hash_q[2] <= hash_q[2] + vars_q.c;
					hash_q[3] <= hash_q[3] + vars_q.d;
					hash_q[4] <= hash_q[4] + vars_q.e;
					hash_q[5] <= hash_q[5] + vars_q.f;
					hash_q[6] <= hash_q[6] + vars_q.g;
					hash_q[7] <= hash_q[7] + vars_q.h;
					if ({1'b0, block_q} + 17'd1 < {1'b0, limit}) begin
						block_q <= block_q + 16'd1;
						state_q <= StIn;
					end else begin
						block_q <= '0;
						oidx_q <= '0;
						state_q <= StOut;
					end
				end
				default: begin
					if (out_beat) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= StIn;
							for (int i = 0; i < 8; i++) hash_q[i] <= init_word(3'(i));
						end
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire
